>>> rtl/ukt_pkg.sv
// Package: widths, status codes and the structs passed along the cell row.
`timescale 1ns / 1ps
package ukt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_W       = 16;
  localparam int VALUE_W     = 24;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 5;
  localparam int TOTAL_W     = 28;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    REQ_ADD    = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic               add_go;
    logic               rem_go;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  // Passed upward from cell i to cell i+1.
  typedef struct packed {
    logic               hit;
    logic               prev_valid;
    logic [VALUE_W-1:0] hit_value;
  } chain_t;

  // Entry contents handed downward on a remove.
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

>>> rtl/ukt_if.sv
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps
interface ukt_req_if import ukt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [KEY_W-1:0]   entry_key;
  logic [VALUE_W-1:0] entry_value;

  modport source (output valid, req_type, entry_key, entry_value, input ready);
  modport sink   (input valid, req_type, entry_key, entry_value, output ready);
endinterface

interface ukt_rsp_if import ukt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;
  logic [TOTAL_W-1:0]  value_total;

  modport source (output valid, status, entry_count, value_total, input ready);
  modport sink   (input valid, status, entry_count, value_total, output ready);
endinterface

>>> rtl/ukt_cell.sv
// Table cell: one entry, key compare, prefix hit chain and shift/append update.
`timescale 1ns / 1ps
module ukt_cell import ukt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cmd_t   cmd,
  input  chain_t chain_in,
  output chain_t chain_out,
  input  entry_t upper,
  output entry_t self
);

  logic               valid;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;
  logic               match;

  assign match = valid && (key == cmd.key);

  assign chain_out.hit        = chain_in.hit | match;
  assign chain_out.prev_valid = valid;
  assign chain_out.hit_value  = chain_in.hit_value | (match ? value : '0);

  assign self.valid = valid;
  assign self.key   = key;
  assign self.value = value;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.rem_go && (chain_in.hit || match)) begin
      valid <= upper.valid;
    end else if (cmd.add_go && !valid && chain_in.prev_valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rem_go && (chain_in.hit || match)) begin
      key   <= upper.key;
      value <= upper.value;
    end else if (cmd.add_go && !valid && chain_in.prev_valid) begin
      key   <= cmd.key;
      value <= cmd.value;
    end
  end

endmodule

>>> rtl/unique_key_table_with_sum.sv
// Top level: unique-key table built as a row of cells, with count and value total.
`timescale 1ns / 1ps
// Packed table of TABLE_DEPTH key/value entries kept in a row of cells. Every
// cell compares its key with the request in the cycle the word is accepted; a
// hit flag ripples up the row so that on a remove each cell at or above the hit
// takes its upper neighbor's entry, and on an add the first empty cell takes
// the new entry. Each request word gives one response word in the next cycle.
// A request is taken whenever the response register is empty or being drained,
// so the block sustains one word per cycle; the hit ripple across the row sets
// the clock path.
module unique_key_table_with_sum import ukt_pkg::*; (
  input logic      clk,
  input logic      rst,
  ukt_req_if.sink  req,
  ukt_rsp_if.source rsp
);

  chain_t chain [0:TABLE_DEPTH];
  entry_t ent   [0:TABLE_DEPTH];
  cmd_t   cmd;

  logic               accept;
  logic               found;
  logic               full;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  status_t            status_next;

  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [COUNT_W-1:0]  rsp_count;
  logic [TOTAL_W-1:0]  rsp_total;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign chain[0].hit        = 1'b0;
  assign chain[0].prev_valid = 1'b1;
  assign chain[0].hit_value  = '0;
  assign ent[TABLE_DEPTH]    = '0;

  assign found = chain[TABLE_DEPTH].hit;
  assign full  = ent[TABLE_DEPTH-1].valid;

  assign cmd.key    = req.entry_key;
  assign cmd.value  = req.entry_value;
  assign cmd.add_go = accept && (req.req_type == REQ_ADD) && !found && !full;
  assign cmd.rem_go = accept && (req.req_type == REQ_REMOVE) && found;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ukt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .upper     (ent[i+1]),
      .self      (ent[i])
    );
  end

  always_comb begin
    count_next  = count;
    total_next  = total;
    status_next = ST_NOTFOUND;
    if (req.req_type == REQ_ADD) begin
      if (found) begin
        status_next = ST_DUPLICATE;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_ADDED;
        count_next  = count + COUNT_W'(1);
        total_next  = total + TOTAL_W'(req.entry_value);
      end
    end else begin
      if (found) begin
        status_next = ST_REMOVED;
        count_next  = count - COUNT_W'(1);
        total_next  = total - TOTAL_W'(chain[TABLE_DEPTH].hit_value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      total     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        total     <= total_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= status_next;
      rsp_count  <= count_next;
      rsp_total  <= total_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.entry_count = rsp_count;
  assign rsp.value_total = rsp_total;

endmodule

>>> rtl/ukt_checker.sv
// Checker: port-level assertions for the table, bound to the top level.
`timescale 1ns / 1ps
module ukt_checker import ukt_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] status,
  input logic [COUNT_W-1:0]  entry_count,
  input logic [TOTAL_W-1:0]  value_total
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_word_answered: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> rsp_valid)
    else $error("accepted request gave no response");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !req_ready)
    else $error("request taken while response stalled");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(status) && $stable(entry_count) && $stable(value_total)))
    else $error("stalled response changed");

endmodule

bind unique_key_table_with_sum ukt_checker u_ukt_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .entry_count (rsp.entry_count),
  .value_total (rsp.value_total)
);
